### hdl/bvp_pkg.sv
// Shared constants, discharge curve tables and stage types for the
// battery voltage to percent block. No dependencies.
package bvp_pkg;

  localparam int CURVE_CAP      = 64;
  localparam int CURVE_PTS_DEF  = 21;
  localparam int MV_W           = 13;
  localparam int PCT_W          = 7;
  localparam int FRAC_SH        = 26;              // fixed-point shift of the slope factor
  localparam int K_W            = PCT_W + FRAC_SH; // slope factor width
  localparam int PROD_W         = MV_W + K_W;
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // Discharge curve, top point first. Unused entries read as 0 mV, 0 percent.
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_CAP] = '{
    0: 13'd4200,  1: 13'd4150,  2: 13'd4110,  3: 13'd4080,  4: 13'd4020,
    5: 13'd3980,  6: 13'd3950,  7: 13'd3910,  8: 13'd3870,  9: 13'd3850,
    10: 13'd3840, 11: 13'd3820, 12: 13'd3800, 13: 13'd3790, 14: 13'd3770,
    15: 13'd3750, 16: 13'd3730, 17: 13'd3710, 18: 13'd3690, 19: 13'd3610,
    20: 13'd3270, default: 13'd0
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_CAP] = '{
    0: 7'd100, 1: 7'd95,  2: 7'd90,  3: 7'd85,  4: 7'd80,
    5: 7'd75,  6: 7'd70,  7: 7'd65,  8: 7'd60,  9: 7'd55,
    10: 7'd50, 11: 7'd45, 12: 7'd40, 13: 7'd35, 14: 7'd30,
    15: 7'd25, 16: 7'd20, 17: 7'd15, 18: 7'd10, 19: 7'd5,
    20: 7'd0,  default: 7'd0
  };

  // Selected segment: result = base + ((x * k) >> FRAC_SH)
  typedef struct packed {
    logic [PCT_W-1:0] base;
    logic [MV_W-1:0]  x;
    logic [K_W-1:0]   k;
  } seg_t;

endpackage

### hdl/bvp_ifs.sv
// Valid/ready channel interfaces for the input samples and the results.
// Depends on bvp_pkg.
interface bvp_in_if import bvp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] voltage_mv;

  modport source (output valid, output voltage_mv, input ready);
  modport sink   (input valid, input voltage_mv, output ready);
endinterface

interface bvp_out_if import bvp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] charge_percent;

  modport source (output valid, output charge_percent, input ready);
  modport sink   (input valid, input charge_percent, output ready);
endinterface

### hdl/bvp_seg_select.sv
// Segment search stage: saturation checks, first matching curve segment,
// offset and slope factor, registered. Depends on bvp_pkg.
module bvp_seg_select import bvp_pkg::*; #(
  parameter int CURVE_POINTS = CURVE_PTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  logic [MV_W-1:0] v,
  output logic            up_ready,
  output logic            dn_valid,
  output seg_t            dn_data,
  input  logic            dn_ready
);

  localparam int NPTS  = (CURVE_POINTS < 2) ? 2 :
                         ((CURVE_POINTS > CURVE_CAP) ? CURVE_CAP : CURVE_POINTS);
  localparam int SEG_N = NPTS - 1;
  localparam int SEG_W = (SEG_N > 1) ? $clog2(SEG_N) : 1;

  logic [SEG_N-1:0] hit;
  logic [MV_W-1:0]  lo_mv_seg  [SEG_N];
  logic [PCT_W-1:0] lo_pct_seg [SEG_N];
  logic [K_W-1:0]   k_seg      [SEG_N];

  for (genvar g = 0; g < SEG_N; g++) begin : g_seg
    localparam logic [MV_W-1:0]  UP_MV = CURVE_MV[g];
    localparam logic [MV_W-1:0]  LO_MV = CURVE_MV[g+1];
    localparam logic [PCT_W-1:0] UP_P  = CURVE_PCT[g];
    localparam logic [PCT_W-1:0] LO_P  = CURVE_PCT[g+1];
    localparam bit     SEG_OK = (UP_MV > LO_MV);
    localparam longint SPAN   = SEG_OK ? (longint'(UP_MV) - longint'(LO_MV)) : 64'sd1;
    localparam longint DP     = (UP_P >= LO_P) ? (longint'(UP_P) - longint'(LO_P)) : 64'sd0;
    // ceil(DP * 2^FRAC_SH / SPAN): exact floor for every offset up to SPAN
    localparam longint KV     = ((DP <<< FRAC_SH) + SPAN - 64'sd1) / SPAN;

    assign hit[g]        = SEG_OK && (v <= UP_MV) && (v >= LO_MV);
    assign lo_mv_seg[g]  = LO_MV;
    assign lo_pct_seg[g] = LO_P;
    assign k_seg[g]      = KV[K_W-1:0];
  end

  logic [SEG_W-1:0] sel;
  seg_t             seg;
  logic             dn_valid_r, dn_valid_nxt;
  seg_t             dn_data_r;

  always_comb begin
    sel = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = SEG_W'(i);
      end
    end
  end

  always_comb begin
    seg = '0;
    priority if (v >= CURVE_MV[0]) begin
      seg.base = CURVE_PCT[0];
    end else if (v <= CURVE_MV[NPTS-1]) begin
      seg.base = CURVE_PCT[NPTS-1];
    end else if (|hit) begin
      seg.base = lo_pct_seg[sel];
      seg.x    = v - lo_mv_seg[sel];
      seg.k    = k_seg[sel];
    end else begin
      seg.base = '0;
    end
  end

  assign up_ready     = !dn_valid_r || dn_ready;
  assign dn_valid_nxt = up_ready ? up_valid : dn_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else begin
      dn_valid_r <= dn_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data_r <= seg;
    end
  end

  assign dn_valid = dn_valid_r;
  assign dn_data  = dn_data_r;

endmodule

### hdl/bvp_interp.sv
// Interpolation stage: offset times slope factor plus segment base,
// into the result register. Depends on bvp_pkg and bvp_ifs.
module bvp_interp import bvp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  seg_t          up_data,
  output logic          up_ready,
  bvp_out_if.source     out_chan
);

  logic [PROD_W-1:0] prod;
  logic [PCT_W-1:0]  frac_q;
  logic [PCT_W-1:0]  pct_nxt;
  logic              valid_r, valid_nxt;
  logic [PCT_W-1:0]  pct_r;

  assign prod    = {{K_W{1'b0}}, up_data.x} * {{MV_W{1'b0}}, up_data.k};
  assign frac_q  = prod[FRAC_SH +: PCT_W];
  assign pct_nxt = up_data.base + frac_q;

  assign up_ready  = !valid_r || out_chan.ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pct_r <= pct_nxt;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.charge_percent = pct_r;

endmodule

### hdl/battery_voltage_to_percent.sv
// An accepted input transaction passes the input, segment search and result
// registers in order before out_chan.valid rises. Throughput: one transaction
// per cycle while out_chan.ready is high; input register, segment search
// register and result register each hold one item and advance independently.
// Reset (rst_n, synchronous, active low) clears the stage valid flags only.
// Top level; depends on bvp_pkg, bvp_ifs, bvp_seg_select, bvp_interp.
module battery_voltage_to_percent import bvp_pkg::*; #(
  parameter int CURVE_POINTS = CURVE_PTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bvp_in_if.sink    in_chan,
  bvp_out_if.source out_chan
);

  logic            in_valid_r, in_valid_nxt;
  logic [MV_W-1:0] v_r;
  logic            sel_ready;
  logic            sel_valid;
  seg_t            sel_data;
  logic            int_ready;

  assign in_chan.ready = !in_valid_r || sel_ready;
  assign in_valid_nxt  = in_chan.ready ? in_chan.valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      v_r <= in_chan.voltage_mv;
    end
  end

  bvp_seg_select #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_seg_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .v        (v_r),
    .up_ready (sel_ready),
    .dn_valid (sel_valid),
    .dn_data  (sel_data),
    .dn_ready (int_ready)
  );

  bvp_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sel_valid),
    .up_data  (sel_data),
    .up_ready (int_ready),
    .out_chan (out_chan)
  );

  // top of curve saturates with a zero slope term
  a_top_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && sel_ready && (v_r >= CURVE_MV[0]))
      |=> (sel_valid && (sel_data.base == CURVE_PCT[0]) && (sel_data.k == '0)))
    else $error("top saturation not applied");

  // a stalled segment stage keeps its item
  a_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_valid && !int_ready) |=> (sel_valid && $stable(sel_data)))
    else $error("segment stage dropped or changed a stalled item");

  // a stalled input register keeps its sample
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !sel_ready) |=> (in_valid_r && $stable(v_r)))
    else $error("input register dropped or changed a stalled item");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.charge_percent <= PCT_MAX))
    else $error("charge percent above full scale");

endmodule

### dv/tb_battery_voltage_to_percent.sv
// Testbench for battery_voltage_to_percent: drives cell voltages over the input channel
// and checks every charge percentage against an in-bench curve interpolation.
// Depends on bvp_pkg, bvp_ifs and the battery_voltage_to_percent RTL.
module tb_battery_voltage_to_percent;
  import bvp_pkg::*;

  localparam int NPTS = 21;

  // Discharge curve, top point first
  localparam int SOC_MV [NPTS] = '{4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870,
                                  3850, 3840, 3820, 3800, 3790, 3770, 3750, 3730, 3710,
                                  3690, 3610, 3270};
  localparam int SOC_PCT [NPTS] = '{100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50, 45, 40,
                                   35, 30, 25, 20, 15, 10, 5, 0};

  logic clk = 1'b0;
  logic rst_n;

  bvp_in_if  in_if ();
  bvp_out_if out_if ();

  battery_voltage_to_percent #(.CURVE_POINTS(NPTS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [PCT_W-1:0] pct_expected_q [$];
  int n_sent     = 0;
  int n_checked  = 0;
  int fail_count = 0;
  int tx_gap_max = 18;
  int rx_gap_max = 18;
  int rx_wait    = 0;
  logic rx_hold  = 1'b0;

  function automatic logic [PCT_W-1:0] soc_for_mv(logic [MV_W-1:0] v);
    int mv;
    int span;
    int dp;
    mv = int'(v);
    if (mv >= SOC_MV[0]) return PCT_W'(SOC_PCT[0]);
    if (mv <= SOC_MV[NPTS-1]) return PCT_W'(SOC_PCT[NPTS-1]);
    for (int i = 0; i + 1 < NPTS; i++) begin
      if (mv > SOC_MV[i] || mv < SOC_MV[i+1]) continue;
      if (SOC_MV[i] <= SOC_MV[i+1]) continue;
      span = SOC_MV[i] - SOC_MV[i+1];
      dp = (SOC_PCT[i] >= SOC_PCT[i+1]) ? SOC_PCT[i] - SOC_PCT[i+1] : 0;
      return PCT_W'(SOC_PCT[i+1] + ((mv - SOC_MV[i+1]) * dp) / span);
    end
    return '0;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_sample(logic [MV_W-1:0] v);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.voltage_mv <= v;
    do @(posedge clk); while (!in_if.ready);
    pct_expected_q.push_back(soc_for_mv(v));
    n_sent++;
  endtask

  task automatic check_result(logic [PCT_W-1:0] got);
    logic [PCT_W-1:0] want;
    if (pct_expected_q.size() == 0) begin
      $error("charge_percent: unexpected result, actual %0d", got);
      fail_count++;
    end else begin
      want = pct_expected_q.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("charge_percent: expected %0d, actual %0d", want, got);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result(out_if.charge_percent);
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        out_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    logic [MV_W-1:0] pts [$];
    pts = '{13'd0, 13'd8191, 13'd4200, 13'd4201, 13'd4199, 13'd3270, 13'd3269, 13'd3271,
            13'd4150, 13'd4110, 13'd3850, 13'd3840, 13'd3790, 13'd3690, 13'd3610,
            13'd4135, 13'd3805, 13'd3440, 13'd3700, 13'd4096};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  task automatic test_random(int count);
    int sel;
    int pt;
    logic [MV_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        sel = $urandom_range(0, 3);
        tx_gap_max = (sel[0]) ? 18 : 0;
        rx_gap_max <= (sel[1]) ? 18 : 0;
      end
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        v = MV_W'($urandom_range(3200, 4300));
      end else if (sel == 8) begin
        pt = SOC_MV[$urandom_range(0, NPTS - 1)];
        v = MV_W'(pt + $urandom_range(0, 4) - 2);
      end else begin
        v = MV_W'($urandom_range(0, 8191));
      end
      send_sample(v);
    end
    tx_gap_max = 18;
    rx_gap_max <= 18;
  endtask

  // Receiver held off while the sender keeps offering back to back
  task automatic test_backpressure();
    tx_gap_max = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (150) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        for (int i = 0; i < 30; i++) send_sample(MV_W'($urandom_range(3200, 4300)));
      end
    join
    tx_gap_max = 18;
  endtask

  // Sender stops until the pipeline is fully drained
  task automatic test_drain_pause();
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 10; i++) send_sample(MV_W'($urandom_range(0, 8191)));
      in_if.valid <= 1'b0;
      while (pct_expected_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.voltage_mv = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(1300);
    test_backpressure();
    test_drain_pause();

    in_if.valid <= 1'b0;
    while (pct_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d samples sent, %0d results checked: curve points, both saturation ends,",
             n_sent, n_checked);
    $display("random sweeps with and without idling, long receiver hold-off, drain pauses");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
